[rtl/core/pth_pkg.sv]
// Shared types, constants and helpers for the permutation test histogram.
package pth_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int WORD_W      = 32;
    localparam int OUT_W       = 32;
    localparam int GROUP_SIZE  = 5;
    localparam int HELD_NUM    = GROUP_SIZE - 1;
    localparam int BIN_NUM     = 121;
    localparam int BIN_W       = 7;
    localparam int FILL_W      = 3;
    localparam int HELD_IDX_W  = 2;
    localparam int RANK_W      = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [BIN_W-1:0]  TIE_BIN    = BIN_W'(120);
    localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(HELD_NUM);

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        OP_REPORT,
        OP_GROUP,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] sample_word;
        logic [BIN_W-1:0]  bin_index;
    } in_t;

    typedef struct packed {
        logic              group_done;
        logic [BIN_W-1:0]  perm_index;
        logic [OUT_W-1:0]  bin_count;
        logic [OUT_W-1:0]  distinct_groups;
    } out_t;

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] addr;
    } cmd_t;

    function automatic count_t sat_inc(input count_t v);
        return (&v) ? v : v + count_t'(1);
    endfunction

endpackage

[rtl/core/permutation_test_histogram.sv]
// Top level of the permutation test histogram: front end, command queue, back end.
//
//   channel   direction  handshake           payload
//   request   in         push / full         pth_pkg::in_t  (action, sample_word, bin_index)
//   result    out        pop / empty         pth_pkg::out_t (group_done .. distinct_groups)
//
// One request per cycle while full stays low; a request passes the compare register, a
// command queue entry and the histogram read register on its way to the result queue.
// Reset clears the histogram at once through per-bin valid bits; no clearing pass.
// With pop low the result queue fills, then the command queue, then full rises.
module permutation_test_histogram (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pth_pkg::in_t  request,
    output logic          empty,
    input  logic          pop,
    output pth_pkg::out_t result
);
    import pth_pkg::*;

    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_out;

    pth_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (cmd_in)
    );

    pth_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .full  (cmd_full),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_out)
    );

    pth_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into a full queue");

    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from an empty queue");

    a_group_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && cmd_in.op == OP_GROUP) |-> (cmd_in.addr <= TIE_BIN))
        else $error("group index beyond the tie bin");

    a_result_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.group_done) |-> (result.perm_index == '0))
        else $error("index shown without a completed group");

endmodule

[rtl/core/pth_front.sv]
// Front end: collects words into groups, compares them and forms commands.
module pth_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pth_pkg::in_t  request,
    output logic          cmd_push,
    input  logic          cmd_full,
    output pth_pkg::cmd_t cmd
);
    import pth_pkg::*;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [WORD_W-1:0]  held_reg [HELD_NUM];
    logic [WORD_W-1:0]  word [GROUP_SIZE];

    logic                                 f1_valid_reg;
    op_t                                  f1_op_reg;
    op_t                                  f1_op_next;
    logic [BIN_W-1:0]                     f1_addr_reg;
    logic [BIN_W-1:0]                     f1_addr_next;
    logic [GROUP_SIZE-1:0][GROUP_SIZE-1:0] f1_gt_reg;
    logic [GROUP_SIZE-1:0][GROUP_SIZE-1:0] gt_next;

    logic                accept;
    logic                f1_ready;
    logic [RANK_W-1:0]   rank [GROUP_SIZE];
    logic [RANK_W-1:0]   tmp;
    logic [RANK_W-1:0]   pos;
    logic [BIN_W-1:0]    f;
    logic                tie;
    logic [BIN_W-1:0]    perm;

    assign f1_ready = !f1_valid_reg || !cmd_full;
    assign full     = !f1_ready;
    assign accept   = push && f1_ready;

    always_comb
    begin
        for (int i = 0; i < HELD_NUM; i++)
        begin
            word[i] = held_reg[i];
        end
        word[HELD_NUM] = request.sample_word;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                gt_next[i][j] = (word[i] > word[j]);
            end
        end
    end

    always_comb
    begin
        fill_next    = fill_reg;
        f1_op_next   = OP_REPORT;
        f1_addr_next = '0;
        case (request.action)
            ACT_SAMPLE:
            begin
                if (fill_reg < FILL_LAST)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                else
                begin
                    fill_next  = '0;
                    f1_op_next = OP_GROUP;
                end
            end
            ACT_READ:
            begin
                if (request.bin_index <= TIE_BIN)
                begin
                    f1_op_next   = OP_READ;
                    f1_addr_next = request.bin_index;
                end
            end
            ACT_CLEAR:
            begin
                fill_next  = '0;
                f1_op_next = OP_CLEAR;
            end
            default:
            begin
                f1_op_next = OP_REPORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (f1_ready)
            begin
                f1_valid_reg <= push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (request.action == ACT_SAMPLE && fill_reg < FILL_LAST)
            begin
                held_reg[fill_reg[HELD_IDX_W-1:0]] <= request.sample_word;
            end
            f1_op_reg   <= f1_op_next;
            f1_addr_reg <= f1_addr_next;
            f1_gt_reg   <= gt_next;
        end
    end

    // Ranks replace the words; with distinct ranks the largest of the first r is r-1.
    always_comb
    begin
        tie = 1'b0;
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                rank[i] = rank[i] + RANK_W'(f1_gt_reg[i][j]);
                if (i < j && !f1_gt_reg[i][j] && !f1_gt_reg[j][i])
                begin
                    tie = 1'b1;
                end
            end
        end
        f   = '0;
        pos = '0;
        tmp = '0;
        for (int r = GROUP_SIZE; r >= 2; r--)
        begin
            pos = '0;
            for (int k = 0; k < r; k++)
            begin
                if (rank[k] == RANK_W'(r - 1))
                begin
                    pos = RANK_W'(k);
                end
            end
            f         = BIN_W'(f * BIN_W'(r)) + BIN_W'(pos);
            tmp       = rank[pos];
            rank[pos] = rank[r - 1];
            rank[r - 1] = tmp;
        end
        perm = tie ? TIE_BIN : f;
    end

    assign cmd_push = f1_valid_reg && !cmd_full;
    assign cmd.op   = f1_op_reg;
    assign cmd.addr = (f1_op_reg == OP_GROUP) ? perm : f1_addr_reg;

endmodule

[rtl/core/pth_queue.sv]
// Short command queue between the front end and the histogram back end.
module pth_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  pth_pkg::cmd_t din,
    input  logic          pop,
    output logic          empty,
    output pth_pkg::cmd_t dout
);
    import pth_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/core/pth_back.sv]
// Back end: histogram memory update and read, counters, result queue.
module pth_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  pth_pkg::cmd_t cmd,
    output logic          empty,
    input  logic          pop,
    output pth_pkg::out_t result
);
    import pth_pkg::*;

    count_t             hist_mem [BIN_NUM];
    logic [BIN_NUM-1:0] valid_reg;
    count_t             rd_reg;
    count_t             distinct_reg;
    count_t             distinct_next;

    logic               a_valid_reg;
    op_t                a_op_reg;
    logic [BIN_W-1:0]   a_addr_reg;

    logic               fwd_valid_reg;
    logic [BIN_W-1:0]   fwd_addr_reg;
    count_t             fwd_data_reg;

    count_t             bin_value;
    count_t             inc_value;
    logic               wr_en;
    out_t               res_next;

    out_t               out_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  out_wr_ptr_reg;
    logic [QPTR_W-1:0]  out_rd_ptr_reg;
    logic [QCNT_W-1:0]  out_count_reg;
    logic               out_pop;

    // Issue only with a free result slot for every request in flight.
    assign cmd_pop = !cmd_empty
        && ((out_count_reg + QCNT_W'(a_valid_reg)) < QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == a_addr_reg)
        begin
            bin_value = fwd_data_reg;
        end
        else if (valid_reg[a_addr_reg])
        begin
            bin_value = rd_reg;
        end
        else
        begin
            bin_value = '0;
        end
        inc_value     = sat_inc(bin_value);
        wr_en         = a_valid_reg && (a_op_reg == OP_GROUP);
        distinct_next = distinct_reg;
        res_next      = '0;
        case (a_op_reg)
            OP_GROUP:
            begin
                if (a_addr_reg != TIE_BIN)
                begin
                    distinct_next = sat_inc(distinct_reg);
                end
                res_next.group_done = 1'b1;
                res_next.perm_index = a_addr_reg;
            end
            OP_READ:
            begin
                res_next.bin_count = OUT_W'(bin_value);
            end
            OP_CLEAR:
            begin
                distinct_next = '0;
            end
            default:
            begin
                distinct_next = distinct_reg;
            end
        endcase
        res_next.distinct_groups = OUT_W'(distinct_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            distinct_reg   <= '0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            a_valid_reg   <= cmd_pop;
            fwd_valid_reg <= wr_en;
            if (a_valid_reg)
            begin
                distinct_reg <= distinct_next;
                if (a_op_reg == OP_CLEAR)
                begin
                    valid_reg <= '0;
                end
                else if (wr_en)
                begin
                    valid_reg[a_addr_reg] <= 1'b1;
                end
                out_wr_ptr_reg <= out_wr_ptr_reg + QPTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= out_rd_ptr_reg + QPTR_W'(1);
            end
            if (a_valid_reg && !out_pop)
            begin
                out_count_reg <= out_count_reg + QCNT_W'(1);
            end
            else if (out_pop && !a_valid_reg)
            begin
                out_count_reg <= out_count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            a_op_reg   <= cmd.op;
            a_addr_reg <= cmd.addr;
            rd_reg     <= hist_mem[cmd.addr];
        end
        if (wr_en)
        begin
            hist_mem[a_addr_reg] <= inc_value;
            fwd_addr_reg         <= a_addr_reg;
            fwd_data_reg         <= inc_value;
        end
        if (a_valid_reg)
        begin
            out_mem[out_wr_ptr_reg] <= res_next;
        end
    end

    assign empty   = (out_count_reg == '0);
    assign out_pop = pop && !empty;
    assign result  = out_mem[out_rd_ptr_reg];

endmodule

[bench/testbench.sv]
// Self-checking bench for the permutation test histogram: random and directed requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pth_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1030;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_CAP = 40;

    logic  clk;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    logic  full;
    in_t   request = '0;
    logic  empty;
    logic  pop = 1'b0;
    out_t  result;

    permutation_test_histogram u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    in_t  pending_requests[$];
    out_t due_results[$];
    out_t want;

    // mirror of the block state
    logic [HELD_NUM-1:0][WORD_W-1:0] held_words;
    logic [FILL_W-1:0]               fill_count = '0;
    count_t                          hist [BIN_NUM];
    count_t                          distinct = '0;

    int total_requests = 0;
    int queued_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int groups_seen = 0;
    int tie_groups = 0;
    int reads_seen = 0;
    int clears_seen = 0;
    bit [TIE_BIN-1:0] codes_hit = '0;

    int stage;
    int send_idle_pct;
    int recv_idle_pct;

    assign stage = (total_requests == 0) ? 2 : sent_count * 3 / total_requests;
    assign send_idle_pct = (stage == 0) ? 18 : (stage == 1) ? 84 : 0;
    assign recv_idle_pct = (stage == 0) ? 84 : (stage == 1) ? 18 : 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic count_t bump_count(input count_t c);
        return (c == '1) ? c : c + count_t'(1);
    endfunction

    // ordering code of five words, tie bin when any two are equal
    function automatic logic [BIN_W-1:0] perm_code(input logic [GROUP_SIZE-1:0][WORD_W-1:0] grp);
        logic [GROUP_SIZE-1:0][WORD_W-1:0] v;
        logic [WORD_W-1:0] t;
        int f;
        int pos;
        v = grp;
        f = 0;
        for (int r = GROUP_SIZE; r >= 2; r--)
        begin
            pos = 0;
            for (int k = 1; k < r; k++)
            begin
                if (v[k] > v[pos])
                    pos = k;
            end
            f = r * f + pos;
            t = v[pos];
            v[pos] = v[r-1];
            v[r-1] = t;
        end
        for (int k = 0; k < GROUP_SIZE - 1; k++)
        begin
            if (v[k] == v[k+1])
                return TIE_BIN;
        end
        return BIN_W'(f);
    endfunction

    task automatic tally_request(input in_t req);
        out_t             want_r;
        logic [BIN_W-1:0] code;
        want_r = '0;
        case (req.action)
            ACT_SAMPLE:
            begin
                if (fill_count < FILL_LAST)
                begin
                    held_words[fill_count[HELD_IDX_W-1:0]] = req.sample_word;
                    fill_count = fill_count + FILL_W'(1);
                end
                else
                begin
                    code = perm_code({req.sample_word, held_words});
                    hist[code] = bump_count(hist[code]);
                    if (code != TIE_BIN)
                    begin
                        distinct = bump_count(distinct);
                        codes_hit[code] = 1'b1;
                    end
                    else
                        tie_groups++;
                    groups_seen++;
                    fill_count = '0;
                    want_r.group_done = 1'b1;
                    want_r.perm_index = code;
                end
            end
            ACT_READ:
            begin
                if (req.bin_index < BIN_NUM)
                    want_r.bin_count = OUT_W'(hist[req.bin_index]);
                reads_seen++;
            end
            ACT_CLEAR:
            begin
                fill_count = '0;
                distinct = '0;
                foreach (hist[i])
                    hist[i] = '0;
                clears_seen++;
            end
            default: ;
        endcase
        want_r.distinct_groups = OUT_W'(distinct);
        due_results.push_back(want_r);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (mismatches < PRINT_CAP)
            $display("result %0d: %s got %h want %h", checked_count, field, got, exp_val);
        mismatches++;
    endtask

    task automatic add_request(input logic [1:0] action, input logic [WORD_W-1:0] word,
                               input logic [BIN_W-1:0] bin);
        in_t req;
        req.action = action;
        req.sample_word = word;
        req.bin_index = bin;
        pending_requests.push_back(req);
        if (action != ACT_UNUSED)
            queued_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
        end
        else if (!push || !full)
        begin
            if (push)
            begin
                tally_request(request);
                sent_count++;
            end
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push <= 1'b1;
                request <= pending_requests.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected result", result.distinct_groups, '0);
                else
                begin
                    want = due_results.pop_front();
                    if (result.group_done !== want.group_done)
                        report_mismatch("group_done", 32'(result.group_done),
                                        32'(want.group_done));
                    if (result.perm_index !== want.perm_index)
                        report_mismatch("perm_index", 32'(result.perm_index),
                                        32'(want.perm_index));
                    if (result.bin_count !== want.bin_count)
                        report_mismatch("bin_count", result.bin_count, want.bin_count);
                    if (result.distinct_groups !== want.distinct_groups)
                        report_mismatch("distinct_groups", result.distinct_groups,
                                        want.distinct_groups);
                end
                checked_count++;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("stalled with %0d requests queued, %0d results due",
                         pending_requests.size(), due_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int               pick;
        int               spread;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] w;

        foreach (hist[i])
            hist[i] = '0;
        held_words = '0;

        // directed: empty reads, ordered groups, a tie, odd actions
        add_request(ACT_READ, $urandom, 7'd0);
        add_request(ACT_READ, $urandom, 7'd127);
        add_request(ACT_SAMPLE, 32'h0000_0000, 7'd0);
        add_request(ACT_SAMPLE, 32'h0000_0001, 7'd127);
        add_request(ACT_SAMPLE, 32'h0000_0002, 7'd0);
        add_request(ACT_SAMPLE, 32'h0000_0003, 7'd127);
        add_request(ACT_SAMPLE, 32'hFFFF_FFFF, 7'd0);
        add_request(ACT_SAMPLE, 32'hFFFF_FFFF, 7'd127);
        add_request(ACT_SAMPLE, 32'hFFFF_FFFE, 7'd0);
        add_request(ACT_SAMPLE, 32'h0000_0002, 7'd127);
        add_request(ACT_SAMPLE, 32'h0000_0001, 7'd0);
        add_request(ACT_SAMPLE, 32'h0000_0000, 7'd127);
        add_request(ACT_SAMPLE, 32'd7, BIN_W'($urandom));
        add_request(ACT_SAMPLE, 32'd3, BIN_W'($urandom));
        add_request(ACT_UNUSED, 32'hFFFF_FFFF, 7'd127);
        add_request(ACT_SAMPLE, 32'd9, BIN_W'($urandom));
        add_request(ACT_READ, 32'hFFFF_FFFF, TIE_BIN);
        add_request(ACT_SAMPLE, 32'd3, BIN_W'($urandom));
        add_request(ACT_SAMPLE, 32'd1, BIN_W'($urandom));
        add_request(ACT_READ, $urandom, TIE_BIN);
        add_request(ACT_READ, $urandom, 7'd121);
        add_request(ACT_CLEAR, 32'hFFFF_FFFF, 7'd127);
        add_request(ACT_READ, $urandom, TIE_BIN);
        add_request(ACT_READ, $urandom, 7'd119);

        queued_count = 0;
        while (queued_count < RANDOM_REQUESTS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // five samples; a narrow spread makes ties likely, the narrowest forces them
                spread = $urandom_range(3);
                base = $urandom;
                for (int k = 0; k < GROUP_SIZE; k++)
                begin
                    case (spread)
                        1: w = $urandom_range(2);
                        2: w = base + $urandom_range(4) - 2;
                        default: w = $urandom;
                    endcase
                    add_request(ACT_SAMPLE, w, BIN_W'($urandom));
                    if ($urandom_range(19) == 0)
                        add_request(ACT_READ, $urandom, BIN_W'($urandom_range(120)));
                end
            end
            else if (pick < 88)
                add_request(ACT_READ, $urandom,
                            BIN_W'(($urandom_range(9) == 0) ? $urandom_range(127, 121)
                                                            : $urandom_range(120)));
            else if (pick < 95)
                add_request(ACT_SAMPLE, $urandom, BIN_W'($urandom));
            else if (pick < 98)
                add_request(ACT_UNUSED, $urandom, BIN_W'($urandom));
            else
                add_request(ACT_CLEAR, $urandom, BIN_W'($urandom));
        end
        total_requests = pending_requests.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_requests || due_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests checked: %0d groups (%0d tied), %0d bin reads, %0d clears",
                 checked_count, groups_seen, tie_groups, reads_seen, clears_seen);
        $display("%0d of 120 tie-free orderings seen, %0d mismatches",
                 $countones(codes_hit), mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
